>>> design/pitch_bin_shift_and_correct_assert.svh
// assertion macros shared by the pitch bin shift and correct design
// no dependencies
`ifndef PITCH_BIN_SHIFT_AND_CORRECT_ASSERT_SVH
`define PITCH_BIN_SHIFT_AND_CORRECT_ASSERT_SVH

// same cycle implication
`define PBSC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next cycle implication
`define PBSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/pbsc_pkg.sv
// shared constants, types and tables for the pitch bin shift and correct design
// no dependencies
package pbsc_pkg;

    localparam int PITCH_BINS      = 448;
    localparam int BINS_PER_OCTAVE = 96;
    // bins per semitone, a power of two
    localparam int SEMI            = BINS_PER_OCTAVE / 12;
    localparam int SEMI_LOG2       = $clog2(SEMI);
    localparam int GRID_SHIFT      = 16 + SEMI_LOG2;
    localparam int HALF_GRID       = SEMI * 32768;
    localparam int SH_MULT         = BINS_PER_OCTAVE * 256 / 12;

    localparam int XW          = 9;
    localparam int TW          = 32;
    localparam int CW          = 16;
    localparam int EW          = 30;
    localparam int LOG_STAGES  = 16;
    localparam int EXP_STAGES  = 16;
    localparam int MIN_MAG     = 7;
    localparam int P_FULL      = 65530;

    typedef enum logic [2:0] {
        REG_AVG      = 3'd0,
        REG_GAIN     = 3'd1,
        REG_SHIFT    = 3'd2,
        REG_STRENGTH = 3'd3,
        REG_CURVE    = 3'd4
    } t_reg_idx;

    typedef enum logic {
        DIV_IDLE,
        DIV_RUN
    } t_div_state;

    typedef struct packed {
        logic signed [CW-1:0] c;
        logic                 neg;
        logic                 zero;
        logic                 corr;
        logic [XW-1:0]        res_nc;
    } t_side;

    // q16 values of 2^(-2^-(idx+1))
    function automatic logic [15:0] exp2_tab(input logic [3:0] idx);
        logic [15:0] v;
        case (idx)
            4'd0:    v = 16'd46341;
            4'd1:    v = 16'd55109;
            4'd2:    v = 16'd60097;
            4'd3:    v = 16'd62757;
            4'd4:    v = 16'd64132;
            4'd5:    v = 16'd64830;
            4'd6:    v = 16'd65182;
            4'd7:    v = 16'd65359;
            4'd8:    v = 16'd65447;
            4'd9:    v = 16'd65492;
            4'd10:   v = 16'd65514;
            4'd11:   v = 16'd65525;
            4'd12:   v = 16'd65530;
            4'd13:   v = 16'd65533;
            4'd14:   v = 16'd65535;
            default: v = 16'd65535;
        endcase
        return v;
    endfunction

endpackage

>>> design/pbsc_recip.sv
// serial restoring divider forming floor(2^32 / d) for the curve type 1 exponent
// depends on pbsc_pkg
module pbsc_recip
    import pbsc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [16:0]   i_divisor,
    output logic          o_busy,
    output logic [EW-1:0] o_quot
);

    t_div_state    r_state, n_state;
    logic [5:0]    r_cnt, n_cnt;
    logic [17:0]   r_rem, n_rem;
    logic [EW-1:0] r_quot, n_quot;
    logic [16:0]   r_div, n_div;
    logic [17:0]   rem_sh;

    assign rem_sh = {r_rem[16:0], (r_cnt == 6'd32)};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_quot  = r_quot;
        n_div   = r_div;
        case (r_state)
            DIV_IDLE: begin
            end
            DIV_RUN: begin
                if (rem_sh >= {1'b0, r_div}) begin
                    n_rem  = rem_sh - {1'b0, r_div};
                    n_quot = {r_quot[EW-2:0], 1'b1};
                end else begin
                    n_rem  = rem_sh;
                    n_quot = {r_quot[EW-2:0], 1'b0};
                end
                if (r_cnt == 6'd0) begin
                    n_state = DIV_IDLE;
                end else begin
                    n_cnt = r_cnt - 6'd1;
                end
            end
            default: n_state = DIV_IDLE;
        endcase
        if (i_start) begin
            n_state = DIV_RUN;
            n_cnt   = 6'd32;
            n_rem   = '0;
            n_quot  = '0;
            n_div   = i_divisor;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
            r_cnt   <= '0;
            r_quot  <= EW'(65536);
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_quot  <= n_quot;
        end
        r_rem <= n_rem;
        r_div <= n_div;
    end

    assign o_busy = (r_state == DIV_RUN);
    assign o_quot = r_quot;

endmodule

>>> design/pbsc_front.sv
// front stages: target pitch, grid point, distance and normalized magnitude
// depends on pbsc_pkg
module pbsc_front
    import pbsc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [XW-1:0]        i_source_pitch,
    input  logic [15:0]          i_avg,
    input  logic signed [15:0]   i_gain,
    input  logic signed [13:0]   i_shift,
    input  logic                 i_curve,
    input  logic                 i_corr,
    input  logic                 i_p_hi,
    output logic                 o_valid,
    output t_side                o_side,
    output logic [16:0]          o_mant,
    output logic [4:0]           o_msb
);

    logic [15:0]          avg_sat;
    logic [23:0]          avg8;
    logic signed [13:0]   sh_sat;
    logic signed [TW-1:0] shterm;

    logic                 r_v1, r_v2, r_v3, r_v4, r_v5;
    logic signed [26:0]   r_diff, n_diff;
    logic signed [42:0]   r_prod, n_prod;
    logic signed [42:0]   rnd;
    logic signed [TW-1:0] r_t, n_t;
    logic signed [TW-1:0] r_t4;
    logic signed [CW-1:0] r_c, n_c;
    logic signed [15:0]   res_w;
    logic [XW-1:0]        r_res_nc, n_res_nc;
    logic signed [TW-1:0] nd;
    logic [TW-1:0]        mag_w;
    logic [16:0]          mag;
    logic [4:0]           msb;
    t_side                r_side, n_side;
    logic [16:0]          r_mant, n_mant;
    logic [4:0]           r_msb;

    assign avg_sat = (i_avg > 16'd32768) ? 16'd32768 : i_avg;
    assign avg8    = {avg_sat, 8'b0};
    assign sh_sat  = (i_shift > 14'sd6144) ? 14'sd6144 :
                     (i_shift < -14'sd6144) ? -14'sd6144 : i_shift;
    assign shterm  = TW'(sh_sat) * TW'(SH_MULT);

    assign n_diff = $signed({2'b0, i_source_pitch, 16'b0}) - $signed({3'b0, avg8});
    assign n_prod = 43'(r_diff) * 43'(i_gain);
    assign rnd    = (r_prod + 43'sd2048) >>> 12;
    assign n_t    = $signed(TW'({8'b0, avg8})) + TW'(rnd) + shterm;

    always_comb begin
        if (i_curve) begin
            n_c = CW'(((r_t + TW'(HALF_GRID)) >>> GRID_SHIFT) <<< 1);
        end else begin
            n_c = CW'(((r_t >>> GRID_SHIFT) <<< 1) + TW'(1));
        end
        res_w = 16'((r_t + TW'(32768)) >>> 16);
        if (res_w < 16'sd1) begin
            n_res_nc = XW'(1);
        end else if (res_w > 16'(PITCH_BINS - 1)) begin
            n_res_nc = XW'(PITCH_BINS - 1);
        end else begin
            n_res_nc = res_w[XW-1:0];
        end
    end

    always_comb begin
        nd    = ((r_t4 <<< 1) >>> SEMI_LOG2) - (TW'(r_c) <<< 16);
        mag_w = nd[TW-1] ? TW'(-nd) : TW'(nd);
        mag   = mag_w[16:0];
        msb   = '0;
        for (int i = 0; i < 17; i++) begin
            if (mag[i]) begin
                msb = 5'(i);
            end
        end
        n_mant        = 17'(mag << (5'd16 - msb));
        n_side.c      = r_c;
        n_side.neg    = nd[TW-1];
        n_side.zero   = i_curve ? ((mag == 17'd0) || i_p_hi) : (mag < 17'(MIN_MAG));
        n_side.corr   = i_corr;
        n_side.res_nc = r_res_nc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
        if (i_en) begin
            r_diff   <= n_diff;
            r_prod   <= n_prod;
            r_t      <= n_t;
            r_t4     <= r_t;
            r_c      <= n_c;
            r_res_nc <= n_res_nc;
            r_side   <= n_side;
            r_mant   <= n_mant;
            r_msb    <= msb;
        end
    end

    assign o_valid = r_v5;
    assign o_side  = r_side;
    assign o_mant  = r_mant;
    assign o_msb   = r_msb;

endmodule

>>> design/pbsc_log2.sv
// log2 fraction by repeated squaring, one squaring per stage
// depends on pbsc_pkg
module pbsc_log2
    import pbsc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [16:0] i_mant,
    input  logic [4:0]  i_msb,
    output logic        o_valid,
    output t_side       o_side,
    output logic [15:0] o_frac,
    output logic [4:0]  o_msb
);

    logic        r_valid [LOG_STAGES];
    t_side       r_side  [LOG_STAGES];
    logic [16:0] r_mant  [LOG_STAGES];
    logic [15:0] r_frac  [LOG_STAGES];
    logic [4:0]  r_msb   [LOG_STAGES];

    for (genvar g = 0; g < LOG_STAGES; g++) begin : g_stage
        logic        src_valid;
        t_side       src_side;
        logic [16:0] src_mant;
        logic [15:0] src_frac;
        logic [4:0]  src_msb;
        logic [33:0] sq;
        logic [17:0] sh;

        if (g == 0) begin : g_first
            assign src_valid = i_valid;
            assign src_side  = i_side;
            assign src_mant  = i_mant;
            assign src_frac  = '0;
            assign src_msb   = i_msb;
        end else begin : g_next
            assign src_valid = r_valid[g-1];
            assign src_side  = r_side[g-1];
            assign src_mant  = r_mant[g-1];
            assign src_frac  = r_frac[g-1];
            assign src_msb   = r_msb[g-1];
        end

        assign sq = 34'(src_mant) * 34'(src_mant);
        assign sh = sq[33:16];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= src_valid;
            end
            if (i_en) begin
                r_side[g] <= src_side;
                r_mant[g] <= sh[17] ? sh[17:1] : sh[16:0];
                r_frac[g] <= {src_frac[14:0], sh[17]};
                r_msb[g]  <= src_msb;
            end
        end
    end

    assign o_valid = r_valid[LOG_STAGES-1];
    assign o_side  = r_side[LOG_STAGES-1];
    assign o_frac  = r_frac[LOG_STAGES-1];
    assign o_msb   = r_msb[LOG_STAGES-1];

endmodule

>>> design/pbsc_exp2.sv
// exponent product and 2^-y by table multiplies, one table entry per stage
// depends on pbsc_pkg
module pbsc_exp2
    import pbsc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  t_side              i_side,
    input  logic [15:0]        i_frac,
    input  logic [4:0]         i_msb,
    input  logic [EW-1:0]      i_e,
    output logic               o_valid,
    output t_side              o_side,
    output logic signed [17:0] o_f
);

    logic [20:0] lg;
    logic [50:0] yprod;
    logic        r_va;
    t_side       r_sa;
    logic [34:0] r_y;
    logic        big;

    logic        r_valid [EXP_STAGES];
    t_side       r_side  [EXP_STAGES];
    logic [16:0] r_r     [EXP_STAGES];
    logic [15:0] r_yf    [EXP_STAGES];
    logic [4:0]  r_yi    [EXP_STAGES];
    logic        r_big   [EXP_STAGES];

    logic               r_vo;
    t_side              r_so;
    logic signed [17:0] r_f;
    logic [16:0]        fmag;

    assign lg    = {5'd16 - i_msb, 16'b0} - {5'b0, i_frac};
    assign yprod = 51'(lg) * 51'(i_e);
    assign big   = (r_y[34:16] > 19'd16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
        end
        if (i_en) begin
            r_sa <= i_side;
            r_y  <= yprod[50:16];
        end
    end

    for (genvar g = 0; g < EXP_STAGES; g++) begin : g_stage
        logic        src_valid;
        t_side       src_side;
        logic [16:0] src_r;
        logic [15:0] src_yf;
        logic [4:0]  src_yi;
        logic        src_big;
        logic [32:0] prod;

        if (g == 0) begin : g_first
            assign src_valid = r_va;
            assign src_side  = r_sa;
            assign src_r     = 17'd65536;
            assign src_yf    = r_y[15:0];
            assign src_yi    = r_y[20:16];
            assign src_big   = big;
        end else begin : g_next
            assign src_valid = r_valid[g-1];
            assign src_side  = r_side[g-1];
            assign src_r     = r_r[g-1];
            assign src_yf    = r_yf[g-1];
            assign src_yi    = r_yi[g-1];
            assign src_big   = r_big[g-1];
        end

        assign prod = 33'(src_r) * 33'(exp2_tab(4'(g))) + 33'd32768;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= src_valid;
            end
            if (i_en) begin
                r_side[g] <= src_side;
                r_r[g]    <= src_yf[15-g] ? prod[32:16] : src_r;
                r_yf[g]   <= src_yf;
                r_yi[g]   <= src_yi;
                r_big[g]  <= src_big;
            end
        end
    end

    assign fmag = (r_big[EXP_STAGES-1] || r_side[EXP_STAGES-1].zero) ? 17'd0 :
                  (r_r[EXP_STAGES-1] >> r_yi[EXP_STAGES-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (i_en) begin
            r_vo <= r_valid[EXP_STAGES-1];
        end
        if (i_en) begin
            r_so <= r_side[EXP_STAGES-1];
            r_f  <= r_side[EXP_STAGES-1].neg ? -$signed({1'b0, fmag}) : $signed({1'b0, fmag});
        end
    end

    assign o_valid = r_vo;
    assign o_side  = r_so;
    assign o_f     = r_f;

endmodule

>>> design/pitch_bin_shift_and_correct.sv
// Pitch bin shift and correct: maps each source pitch bin to a shifted, gain scaled
// and optionally semitone snapped bin. One transfer per cycle in steady state, while
// i_ready is high and no register write or reciprocal is in progress. A write to
// correction_strength starts a serial reciprocal that holds off input transfers.
// depends on pbsc_pkg, pbsc_front, pbsc_log2, pbsc_exp2, pbsc_recip and the assert header
module pitch_bin_shift_and_correct
    import pbsc_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [XW-1:0] i_source_pitch,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [XW-1:0] o_mapped_pitch,
    input  logic          i_psel,
    input  logic          i_penable,
    input  logic          i_pwrite,
    input  logic [4:0]    i_paddr,
    input  logic [31:0]   i_pwdata,
    output logic [31:0]   o_prdata,
    output logic          o_pready
);

`include "pitch_bin_shift_and_correct_assert.svh"

    logic [15:0]        r_avg;
    logic signed [15:0] r_gain;
    logic signed [13:0] r_shift;
    logic [16:0]        r_strength;
    logic               r_curve;

    logic         w_en, w_wr, w_busy, w_start;
    t_reg_idx     w_idx;
    logic [16:0]  p_sat, p_new, e0;
    logic         p_hi, corr;
    logic [EW-1:0] w_quot, w_e;

    logic         w_fv, w_lv, w_ev;
    t_side        w_fs, w_ls, w_es;
    logic [16:0]  w_mant;
    logic [4:0]   w_fmsb, w_lmsb;
    logic [15:0]  w_frac;
    logic signed [17:0] w_f;

    logic signed [39:0] v, w;
    logic [XW-1:0]      n_pitch, r_out_pitch;
    logic               r_out_valid;

    assign w_en     = !r_out_valid || i_ready;
    assign w_wr     = i_psel && i_penable && i_pwrite;
    assign w_idx    = t_reg_idx'(i_paddr[4:2]);
    assign o_ready  = w_en && !w_busy && !w_wr;
    assign o_pready = 1'b1;

    assign p_sat = (r_strength > 17'd65536) ? 17'd65536 : r_strength;
    assign p_hi  = (p_sat >= 17'(P_FULL));
    assign corr  = (p_sat != 17'd0);
    assign e0    = 17'(18'd65536 - {1'b0, p_sat});
    assign w_e   = r_curve ? w_quot : EW'(e0);

    assign p_new   = (i_pwdata[16:0] > 17'd65536) ? 17'd65536 : i_pwdata[16:0];
    assign w_start = w_wr && (w_idx == REG_STRENGTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg      <= '0;
            r_gain     <= 16'sd4096;
            r_shift    <= '0;
            r_strength <= '0;
            r_curve    <= 1'b0;
        end else if (w_wr) begin
            case (w_idx)
                REG_AVG:      r_avg      <= i_pwdata[15:0];
                REG_GAIN:     r_gain     <= $signed(i_pwdata[15:0]);
                REG_SHIFT:    r_shift    <= $signed(i_pwdata[13:0]);
                REG_STRENGTH: r_strength <= i_pwdata[16:0];
                REG_CURVE:    r_curve    <= i_pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_AVG:      o_prdata = {16'b0, r_avg};
            REG_GAIN:     o_prdata = {16'b0, r_gain};
            REG_SHIFT:    o_prdata = {18'b0, r_shift};
            REG_STRENGTH: o_prdata = {15'b0, r_strength};
            REG_CURVE:    o_prdata = {31'b0, r_curve};
            default:      o_prdata = '0;
        endcase
    end

    pbsc_recip u_recip (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_start),
        .i_divisor (17'(18'd65536 - {1'b0, p_new})),
        .o_busy    (w_busy),
        .o_quot    (w_quot)
    );

    pbsc_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (i_valid && o_ready),
        .i_source_pitch (i_source_pitch),
        .i_avg          (r_avg),
        .i_gain         (r_gain),
        .i_shift        (r_shift),
        .i_curve        (r_curve),
        .i_corr         (corr),
        .i_p_hi         (p_hi),
        .o_valid        (w_fv),
        .o_side         (w_fs),
        .o_mant         (w_mant),
        .o_msb          (w_fmsb)
    );

    pbsc_log2 u_log2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_side  (w_fs),
        .i_mant  (w_mant),
        .i_msb   (w_fmsb),
        .o_valid (w_lv),
        .o_side  (w_ls),
        .o_frac  (w_frac),
        .o_msb   (w_lmsb)
    );

    pbsc_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_lv),
        .i_side  (w_ls),
        .i_frac  (w_frac),
        .i_msb   (w_lmsb),
        .i_e     (w_e),
        .o_valid (w_ev),
        .o_side  (w_es),
        .o_f     (w_f)
    );

    always_comb begin
        v = (40'(w_es.c) <<< 16) + 40'(w_f);
        w = ((v <<< SEMI_LOG2) + 40'sd65536) >>> 17;
        if (!w_es.corr) begin
            n_pitch = w_es.res_nc;
        end else if (w < 40'sd1) begin
            n_pitch = XW'(1);
        end else if (w > 40'(PITCH_BINS - 1)) begin
            n_pitch = XW'(PITCH_BINS - 1);
        end else begin
            n_pitch = w[XW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_ev;
        end
        if (w_en) begin
            r_out_pitch <= n_pitch;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_mapped_pitch = r_out_pitch;

    `PBSC_ASSERT_NOW(a_out_range, i_clk, i_rst_n, o_valid, (o_mapped_pitch != '0) && (o_mapped_pitch <= XW'(PITCH_BINS - 1)), "mapped pitch out of range")
    `PBSC_ASSERT_NEXT(a_strength_busy, i_clk, i_rst_n, w_start, w_busy && !o_ready, "reciprocal not started")
    `PBSC_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, o_valid && !i_ready, $stable(w_ev) && $stable(w_lv), "pipeline moved during stall")

endmodule
